// ===== design/mpu_pkg.sv =====
// mpu_pkg: beat types, register map, masks and reset constants for the
// memory protection unit. No dependencies.
`timescale 1ns / 1ps
package mpu_pkg;

  // Walk index width in commands; it allows up to 8 descriptors.
  localparam int DescIdxW = 3;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_CHECK = 2'd2;

  localparam logic [1:0] REQ_CPU  = 2'd0;
  localparam logic [1:0] REQ_COPR = 2'd1;

  localparam logic [3:0] OFF_FLAG   = 4'd0;
  localparam logic [3:0] OFF_SELECT = 4'd5;
  localparam logic [3:0] OFF_DESC0  = 4'd6;
  localparam logic [3:0] OFF_DESC3  = 4'd9;
  localparam logic [3:0] OFF_LAST   = 4'd11;

  localparam logic [7:0] MASK_SELECT = 8'h87;
  localparam logic [7:0] MASK_DESC3  = 8'hCF;
  localparam logic [7:0] MASK_FLAG   = 8'hE1;

  localparam logic [7:0] APPLY_CPU   = 8'hC0;
  localparam logic [7:0] APPLY_COPR  = 8'h20;
  localparam logic [7:0] APPLY_OTHER = 8'h10;

  // Descriptor bytes, byte 0 in the low byte.
  localparam logic [5:0][7:0] DESC_RESET  = 48'hFFFF_0F00_0000;
  localparam logic [5:0][7:0] DESC0_RESET = 48'hFFFF_0F00_00E0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  reg_offset;
    logic [7:0]  write_data;
    logic [1:0]  requester;
    logic [22:0] access_addr;
    logic [3:0]  access_size;
    logic        is_write;
    logic        is_execute;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       offset_ok;
    logic       violation;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic                accept;  // input beat taken this cycle
    logic                step;    // evaluate descriptor idx for the check
    logic                finish;  // close the check and load the result
    logic [DescIdxW-1:0] idx;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_check;   // pending input beat is an access check
    logic out_valid;  // result register holds a beat
  } status_t;

endpackage

// ===== design/mpu_ctrl.sv =====
// mpu_ctrl: handshake and descriptor-walk sequencer.
// Depends on mpu_pkg.
`timescale 1ns / 1ps
module mpu_ctrl #(
  parameter int NUM_DESCRIPTORS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_stall,
  input  mpu_pkg::status_t status,
  output mpu_pkg::cmd_t   cmd
);
  import mpu_pkg::*;

  localparam int IdxW = (NUM_DESCRIPTORS > 1) ? $clog2(NUM_DESCRIPTORS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_DESCRIPTORS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t          state;
  logic [IdxW-1:0] cnt;
  logic            out_free;
  logic            accept;
  logic            last;

  assign out_free = !status.out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign last     = (cnt == LastIdx);

  always_comb begin
    cmd        = '0;
    cmd.accept = accept;
    cmd.step   = (state == ST_WALK);
    cmd.finish = (state == ST_WALK) && last && out_free;
    cmd.idx    = DescIdxW'(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (accept && status.is_check) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!last) begin
            cnt <= cnt + 1'b1;
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/mpu_datapath.sv =====
// mpu_datapath: descriptor store, select and flag registers, register window,
// range compare and result register. Depends on mpu_pkg.
`timescale 1ns / 1ps
module mpu_datapath #(
  parameter int NUM_DESCRIPTORS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  mpu_pkg::in_t    in_data,
  input  mpu_pkg::cmd_t   cmd,
  input  logic            out_stall,
  output mpu_pkg::status_t status,
  output logic            out_valid,
  output mpu_pkg::out_t   out_data
);
  import mpu_pkg::*;

  localparam int IdxW = (NUM_DESCRIPTORS > 1) ? $clog2(NUM_DESCRIPTORS) : 1;

  logic [5:0][7:0] desc [NUM_DESCRIPTORS];
  logic [7:0]      select;
  logic            err_flag;

  // latched check
  logic [7:0]  chk_mbits;
  logic [22:0] chk_start;
  logic [23:0] chk_end;
  logic        chk_wr;
  logic        chk_ex;
  logic        acc;

  logic [IdxW-1:0] rd_idx;
  logic [5:0][7:0] rd_desc;
  logic            win_ok;
  logic [2:0]      byte_sel;
  logic [7:0]      rd_byte;
  logic [7:0]      reg_rdata;
  logic            off_ok;
  logic [23:0]     last_addr;
  logic [7:0]      mbits;
  logic [22:0]     lo;
  logic [22:0]     hi;
  logic            hit;
  logic            is_reg;
  logic            desc_wr;
  logic [7:0]      wr_byte;

  assign status.is_check  = (in_data.kind == KIND_CHECK);
  assign status.out_valid = out_valid;

  // single read port: walk index during a check, window index otherwise
  assign rd_idx  = cmd.step ? cmd.idx[IdxW-1:0] : select[IdxW-1:0];
  assign rd_desc = desc[rd_idx];

  assign win_ok   = {1'b0, select[2:0]} < 4'(NUM_DESCRIPTORS);
  assign byte_sel = 3'(in_data.reg_offset - OFF_DESC0);
  assign rd_byte  = rd_desc[byte_sel];
  assign off_ok   = (in_data.reg_offset <= OFF_LAST);
  assign is_reg   = (in_data.kind == KIND_READ) || (in_data.kind == KIND_WRITE);

  always_comb begin
    case (in_data.reg_offset) inside
      OFF_FLAG:   reg_rdata = {err_flag, 7'b0} & MASK_FLAG;
      OFF_SELECT: reg_rdata = select;
      [OFF_DESC0:OFF_LAST]: begin
        if (!win_ok) begin
          reg_rdata = 8'h00;
        end else if (in_data.reg_offset == OFF_DESC3) begin
          reg_rdata = rd_byte & MASK_DESC3;
        end else begin
          reg_rdata = rd_byte;
        end
      end
      default: reg_rdata = 8'h00;
    endcase
  end

  assign desc_wr = cmd.accept && (in_data.kind == KIND_WRITE) && win_ok
                   && (in_data.reg_offset >= OFF_DESC0)
                   && (in_data.reg_offset <= OFF_LAST);
  assign wr_byte = (in_data.reg_offset == OFF_DESC3) ?
                   (in_data.write_data & MASK_DESC3) : in_data.write_data;

  always_comb begin
    case (in_data.requester)
      REQ_CPU:  mbits = APPLY_CPU;
      REQ_COPR: mbits = APPLY_COPR;
      default:  mbits = APPLY_OTHER;
    endcase
  end

  // zero size counts as one byte
  assign last_addr = {1'b0, in_data.access_addr}
                   + ((in_data.access_size == 4'd0) ? 24'd0
                                                    : 24'(in_data.access_size - 4'd1));

  assign lo  = {rd_desc[0][3:0], rd_desc[1], rd_desc[2], 3'b000};
  assign hi  = {rd_desc[3][3:0], rd_desc[4], rd_desc[5], 3'b111};
  assign hit = |(rd_desc[0] & chk_mbits)
               && (chk_start <= hi) && (chk_end >= {1'b0, lo})
               && ((chk_wr && rd_desc[3][7]) || (chk_ex && rd_desc[3][6]));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DESCRIPTORS; i++) begin
        desc[i] <= (i == 0) ? DESC0_RESET : DESC_RESET;
      end
      select    <= '0;
      err_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept && in_data.kind == KIND_WRITE) begin
        if (in_data.reg_offset == OFF_FLAG && in_data.write_data[7]) begin
          err_flag <= 1'b0;
        end
        if (in_data.reg_offset == OFF_SELECT) begin
          select <= in_data.write_data & MASK_SELECT;
        end
      end
      if (desc_wr) begin
        desc[select[IdxW-1:0]][byte_sel] <= wr_byte;
      end
      if (cmd.finish && (acc || hit)) begin
        err_flag <= 1'b1;
      end
      if ((cmd.accept && !status.is_check) || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: check operands, accumulator and result beat
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      chk_mbits <= mbits;
      chk_start <= {in_data.access_addr[22:3], 3'b000};
      chk_end   <= {last_addr[23:3], 3'b000};
      chk_wr    <= in_data.is_write;
      chk_ex    <= in_data.is_execute;
      acc       <= 1'b0;
      out_data  <= '0;
      if (is_reg) begin
        out_data.offset_ok <= off_ok;
        if (in_data.kind == KIND_READ && off_ok) begin
          out_data.read_data <= reg_rdata;
        end
      end
    end else if (cmd.step) begin
      acc <= acc | hit;
    end
    if (cmd.finish) begin
      out_data.read_data <= 8'h00;
      out_data.offset_ok <= 1'b1;
      out_data.violation <= acc | hit;
    end
  end

endmodule

// ===== design/memory_protection_unit_core.sv =====
// memory_protection_unit_core: top level of the memory protection unit.
// Instantiates mpu_ctrl and mpu_datapath; depends on mpu_pkg.
`timescale 1ns / 1ps
//
//   channel | direction | handshake            | beat type
//   --------+-----------+----------------------+----------------
//   in      | input     | in_valid / in_stall  | mpu_pkg::in_t
//   out     | output    | out_valid / out_stall| mpu_pkg::out_t
//
// Register reads and writes load their result beat into the output
// register at the accept edge.
// An access check walks the descriptor store one entry per cycle through a
// single read port, holding the last entry until the result register is free.
// One beat is in flight at a time; in_stall is high during a walk and while
// an unconsumed result sits under out_stall.
// Reset (rst, synchronous) restores all descriptors, select and the flag.
module memory_protection_unit_core #(
  parameter int NUM_DESCRIPTORS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  mpu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mpu_pkg::out_t out_data
);
  import mpu_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: owns the handshake and the walk counter
  mpu_ctrl #(
    .NUM_DESCRIPTORS(NUM_DESCRIPTORS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // storage, window decode, range compare and result register
  mpu_datapath #(
    .NUM_DESCRIPTORS(NUM_DESCRIPTORS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_stall(out_stall),
    .status   (status),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

// ===== dv/memory_protection_unit_core_test.sv =====
// memory_protection_unit_core_test: self-checking bench for the memory protection unit.
// Sends directed and random beats, predicts each reply and checks it; depends on mpu_pkg.
`timescale 1ns / 1ps
module memory_protection_unit_core_test;
  import mpu_pkg::*;

  localparam int DESC_COUNT   = 8;
  localparam int CHECK_CYCLES = DESC_COUNT + 1;  // walk length of one access check
  localparam int RANDOM_BEATS = 600;
  localparam int MAX_REPORTS  = 100;

  localparam logic [1:0] KIND_NONE = 2'd3;   // unused kind, block replies with an all-zero beat
  localparam logic [1:0] REQ_OTHER = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;   // also treated as other master
  localparam logic [3:0] OFF_RSVD  = 4'd4;
  localparam logic [7:0] FORBID_WR = 8'h80;  // descriptor byte 3
  localparam logic [7:0] FORBID_EX = 8'h40;
  localparam logic [7:0] FLAG_ERR  = 8'h80;  // access error flag, write 1 to clear

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  memory_protection_unit_core #(
    .NUM_DESCRIPTORS(DESC_COUNT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the block state, advanced once per accepted input beat.
  logic [7:0] desc_img [DESC_COUNT][6];
  logic [7:0] select_img;
  logic [7:0] flag_img;

  out_t reply_fifo [$];   // predicted reply beats, oldest first
  int   mismatches = 0;
  int   beats_sent = 0;   // beats that the block acts on
  int   burst_left = 0;

  // Descriptor range bounds at byte resolution.
  function automatic int unsigned range_low(int e);
    return {9'd0, desc_img[e][0][3:0], desc_img[e][1], desc_img[e][2], 3'b000};
  endfunction

  function automatic int unsigned range_high(int e);
    return {9'd0, desc_img[e][3][3:0], desc_img[e][4], desc_img[e][5], 3'b111};
  endfunction

  // Reply for one input beat; updates the shadow state as the block would.
  function automatic out_t mpu_evaluate(in_t b);
    out_t        r;
    int          win;
    int unsigned first_al;
    int unsigned last_al;
    logic [7:0]  who;
    r   = '0;
    win = int'(select_img[2:0]);
    if (b.kind == KIND_READ || b.kind == KIND_WRITE) begin
      if (b.reg_offset <= OFF_LAST) begin
        r.offset_ok = 1'b1;
        if (b.kind == KIND_READ) begin
          if (b.reg_offset == OFF_FLAG) begin
            r.read_data = flag_img & MASK_FLAG;
          end else if (b.reg_offset == OFF_SELECT) begin
            r.read_data = select_img & MASK_SELECT;
          end else if (b.reg_offset >= OFF_DESC0 && win < DESC_COUNT) begin
            r.read_data = desc_img[win][b.reg_offset - OFF_DESC0];
            if (b.reg_offset == OFF_DESC3) r.read_data = r.read_data & MASK_DESC3;
          end
        end else begin
          if (b.reg_offset == OFF_FLAG) begin
            if ((b.write_data & FLAG_ERR) != 0) flag_img = flag_img & ~FLAG_ERR;
          end else if (b.reg_offset == OFF_SELECT) begin
            select_img = b.write_data & MASK_SELECT;
          end else if (b.reg_offset >= OFF_DESC0 && win < DESC_COUNT) begin
            desc_img[win][b.reg_offset - OFF_DESC0] =
                (b.reg_offset == OFF_DESC3) ? (b.write_data & MASK_DESC3) : b.write_data;
          end
        end
      end
    end else if (b.kind == KIND_CHECK) begin
      r.offset_ok = 1'b1;
      // end address at full width, no wrap; size 0 counts as one byte
      first_al = 32'(b.access_addr) & ~32'h7;
      last_al  = (32'(b.access_addr) + (b.access_size == 0 ? 32'd0 : 32'(b.access_size) - 1))
                 & ~32'h7;
      who = (b.requester == REQ_CPU)  ? APPLY_CPU :
            (b.requester == REQ_COPR) ? APPLY_COPR : APPLY_OTHER;
      for (int e = 0; e < DESC_COUNT; e++) begin
        if ((desc_img[e][0] & who) != 0 && first_al <= range_high(e) &&
            last_al >= range_low(e)) begin
          if ((b.is_write && (desc_img[e][3] & FORBID_WR) != 0) ||
              (b.is_execute && (desc_img[e][3] & FORBID_EX) != 0))
            r.violation = 1'b1;
        end
      end
      if (r.violation) flag_img = flag_img | FLAG_ERR;
    end
    return r;
  endfunction

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // Append one predicted reply at the tail of the queue.
  task automatic enqueue_reply(out_t r);
    reply_fifo.insert(reply_fifo.size(), r);
  endtask

  // Reply checker and predictor. Output side first: the reply accepted at an
  // edge always belongs to an earlier input beat.
  always @(posedge clk) begin : scoreboard
    out_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (reply_fifo.size() == 0) begin
          log_mismatch($sformatf("reply beat %h with none expected", out_data));
        end else begin
          want = reply_fifo.pop_front();
          if (out_data.read_data !== want.read_data)
            log_mismatch($sformatf("read_data %h, expected %h",
                                   out_data.read_data, want.read_data));
          if (out_data.offset_ok !== want.offset_ok)
            log_mismatch($sformatf("offset_ok %b, expected %b",
                                   out_data.offset_ok, want.offset_ok));
          if (out_data.violation !== want.violation)
            log_mismatch($sformatf("violation %b, expected %b",
                                   out_data.violation, want.violation));
        end
      end
      if (in_valid && !in_stall) enqueue_reply(mpu_evaluate(in_data));
    end
  end

  // Receiver stalls from a 32-bit pattern, reloaded each round: none,
  // light, sparse or heavy.
  logic [31:0] stall_bits  = '0;
  logic [4:0]  stall_phase = '0;
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_bits = '0;
        1:       stall_bits = $urandom;
        2:       stall_bits = $urandom & $urandom;
        default: stall_bits = $urandom | $urandom;
      endcase
    end
    out_stall <= stall_bits[stall_phase];
    stall_phase = stall_phase + 1'b1;
  end

  function automatic in_t random_beat();
    in_t b;
    b.kind        = 2'($urandom_range(0, 3));
    b.reg_offset  = 4'($urandom);
    b.write_data  = 8'($urandom);
    b.requester   = 2'($urandom);
    b.access_addr = 23'($urandom);
    b.access_size = 4'($urandom);
    b.is_write    = 1'($urandom);
    b.is_execute  = 1'($urandom);
    return b;
  endfunction

  // Offer one beat, hold it until accepted, then maybe open a gap.
  task automatic push_beat(in_t b);
    int gap;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (b.kind != KIND_NONE && (b.kind == KIND_CHECK || b.reg_offset <= OFF_LAST))
      beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic reg_op(logic [1:0] k, logic [3:0] off, logic [7:0] data);
    in_t b;
    b            = random_beat();
    b.kind       = k;
    b.reg_offset = off;
    b.write_data = data;
    push_beat(b);
  endtask

  task automatic check_op(logic [1:0] who, int unsigned addr, logic [3:0] size,
                          logic wr, logic ex);
    in_t b;
    b             = random_beat();
    b.kind        = KIND_CHECK;
    b.requester   = who;
    b.access_addr = addr[22:0];
    b.access_size = size;
    b.is_write    = wr;
    b.is_execute  = ex;
    push_beat(b);
  endtask

  // Register window: masks, status/reserved bytes, undefined offsets, unused kind.
  task automatic test_register_window();
    reg_op(KIND_READ, OFF_FLAG, 8'h00);
    for (int o = OFF_FLAG + 1; o <= OFF_RSVD; o++) reg_op(KIND_READ, 4'(o), 8'hFF);
    reg_op(KIND_WRITE, 4'(OFF_RSVD - 1), 8'hFF);      // status byte ignores writes
    reg_op(KIND_READ, 4'(OFF_RSVD - 1), 8'h00);
    reg_op(KIND_WRITE, OFF_SELECT, 8'hFF);            // select 7 through mask
    reg_op(KIND_READ, OFF_SELECT, 8'h00);
    reg_op(KIND_READ, OFF_DESC3, 8'h00);
    reg_op(KIND_READ, OFF_LAST, 8'h00);
    reg_op(KIND_WRITE, OFF_DESC3, 8'hFF);             // byte 3 mask
    reg_op(KIND_READ, OFF_DESC3, 8'h00);
    reg_op(KIND_WRITE, OFF_SELECT, 8'h00);
    reg_op(KIND_READ, OFF_DESC0, 8'h00);              // entry 0 reset apply bits
    reg_op(KIND_READ, 4'(OFF_LAST + 1), 8'h00);       // undefined offsets
    reg_op(KIND_WRITE, 4'hF, 8'hFF);
    reg_op(KIND_NONE, OFF_SELECT, 8'hFF);
  endtask

  // Access checks: requester match, forbid bits, flag set/clear, range edges,
  // zero and oversize accesses, end past the top of the address space.
  task automatic test_access_checks();
    reg_op(KIND_WRITE, OFF_DESC3, FORBID_WR | FORBID_EX | 8'h0F);  // entry 0, whole space
    check_op(REQ_CPU, 0, 4'd1, 1'b1, 1'b0);
    check_op(REQ_OTHER, 0, 4'd1, 1'b1, 1'b1);         // entry 0 not for other master
    check_op(REQ_COPR, 32'h7FFFFF, 4'd8, 1'b0, 1'b1);
    check_op(REQ_CPU, 32'h1234, 4'd4, 1'b0, 1'b0);    // plain read never flags
    reg_op(KIND_READ, OFF_FLAG, 8'h00);
    reg_op(KIND_WRITE, OFF_FLAG, 8'h7F);              // bit 7 clear: flag stays
    reg_op(KIND_READ, OFF_FLAG, 8'h00);
    reg_op(KIND_WRITE, OFF_FLAG, FLAG_ERR);
    reg_op(KIND_READ, OFF_FLAG, 8'h00);
    reg_op(KIND_WRITE, OFF_DESC3, 8'h0F);
    // entry 1: other master, bytes 0x100..0x107, write forbidden
    reg_op(KIND_WRITE, OFF_SELECT, 8'h01);
    reg_op(KIND_WRITE, OFF_DESC0, APPLY_OTHER);
    reg_op(KIND_WRITE, 4'(OFF_DESC0 + 2), 8'h20);
    reg_op(KIND_WRITE, OFF_DESC3, FORBID_WR);
    reg_op(KIND_WRITE, 4'(OFF_DESC3 + 1), 8'h00);
    reg_op(KIND_WRITE, OFF_LAST, 8'h20);
    check_op(REQ_OTHER, 32'hF8, 4'd8, 1'b1, 1'b0);    // ends one byte short
    check_op(REQ_OTHER, 32'hF8, 4'd9, 1'b1, 1'b0);    // reaches the range
    check_op(REQ_SPARE, 32'h108, 4'd0, 1'b1, 1'b0);   // past the range, size 0
    check_op(REQ_SPARE, 32'h107, 4'd15, 1'b1, 1'b1);
    // entry 2: top granule only; end must not wrap to zero
    reg_op(KIND_WRITE, OFF_SELECT, 8'h82);
    reg_op(KIND_WRITE, OFF_DESC0, APPLY_CPU | 8'h0F);
    reg_op(KIND_WRITE, 4'(OFF_DESC0 + 1), 8'hFF);
    reg_op(KIND_WRITE, 4'(OFF_DESC0 + 2), 8'hFF);
    reg_op(KIND_WRITE, OFF_DESC3, FORBID_WR | 8'h0F);
    check_op(REQ_CPU, 32'h7FFFFC, 4'd8, 1'b1, 1'b0);
    check_op(REQ_CPU, 32'h7FFFF0, 4'd8, 1'b1, 1'b0);
  endtask

  // Mostly checks aimed at the ranges, with descriptor programming,
  // flag traffic and fully random beats mixed in.
  task automatic test_random_traffic();
    int          goal;
    int          pick;
    int          e;
    int unsigned lo;
    int unsigned hi;
    int unsigned addr;
    logic [3:0]  size;
    goal = beats_sent + RANDOM_BEATS;
    while (beats_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        e  = $urandom_range(0, DESC_COUNT - 1);
        lo = $urandom_range(0, 20'hFFFFF);                // range in 8-byte granules
        hi = ($urandom_range(0, 3) == 0) ? lo + $urandom_range(0, 20'hFFFFF)
                                         : lo + $urandom_range(0, 8);
        if ($urandom_range(0, 9) == 0 && lo > 0) hi = lo - 1;  // empty range
        if (hi > 20'hFFFFF) hi = 20'hFFFFF;
        reg_op(KIND_WRITE, OFF_SELECT, 8'(e) | (8'($urandom) & 8'hF8));
        reg_op(KIND_WRITE, OFF_DESC0, (8'($urandom) & 8'hF0) | 8'(lo >> 16));
        reg_op(KIND_WRITE, 4'(OFF_DESC0 + 1), 8'(lo >> 8));
        reg_op(KIND_WRITE, 4'(OFF_DESC0 + 2), 8'(lo));
        reg_op(KIND_WRITE, OFF_DESC3, (8'($urandom) & 8'hF0) | 8'(hi >> 16));
        reg_op(KIND_WRITE, 4'(OFF_DESC3 + 1), 8'(hi >> 8));
        reg_op(KIND_WRITE, OFF_LAST, 8'(hi));
        if ($urandom_range(0, 1) == 1)
          reg_op(KIND_READ, 4'(OFF_DESC0 + $urandom_range(0, 5)), 8'($urandom));
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 6)) begin
          e = $urandom_range(0, DESC_COUNT - 1);
          if ($urandom_range(0, 4) == 0) begin
            addr = $urandom_range(0, 23'h7FFFFF);
          end else begin
            addr = (($urandom_range(0, 1) == 1) ? range_low(e) : range_high(e))
                   + $urandom_range(0, 32) - 16;
            if (addr > 32'h7FFFFFFF) addr = 0;
            else if (addr > 32'h7FFFFF) addr = 32'h7FFFFF;
          end
          size = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 8));
          check_op(2'($urandom_range(0, 3)), addr, size, 1'($urandom), 1'($urandom));
        end
      end else if (pick < 85) begin
        reg_op(KIND_READ, OFF_FLAG, 8'($urandom));
        reg_op(KIND_WRITE, OFF_FLAG, 8'($urandom));
      end else begin
        push_beat(random_beat());
      end
    end
  endtask

  initial begin
    for (int e = 0; e < DESC_COUNT; e++)
      for (int k = 0; k < 6; k++) desc_img[e][k] = DESC_RESET[k];
    for (int k = 0; k < 6; k++) desc_img[0][k] = DESC0_RESET[k];
    select_img = '0;
    flag_img   = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_window();
    test_access_checks();
    test_random_traffic();
    in_valid <= 1'b0;

    // drain, then give a trailing reply time to show up
    while (reply_fifo.size() != 0) @(posedge clk);
    repeat (CHECK_CYCLES + 8) @(posedge clk);
    if (mismatches == 0 && reply_fifo.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== memory_protection_unit_core.f =====
design/mpu_pkg.sv
design/mpu_ctrl.sv
design/mpu_datapath.sv
design/memory_protection_unit_core.sv
dv/memory_protection_unit_core_test.sv
